FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define DFR_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframer assertion failed");

// Assertion that is checked during reset as well.
`define DFR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("deframer assertion failed");

`endif

FILE: hdl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and constants shared by the word stream deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  localparam int CHANNELS   = 16;
  localparam int CH_W       = 4;
  localparam int WORD_W     = 32;
  localparam int LIMIT_W    = 20;
  localparam int COUNT_W    = 21;
  localparam int LEFT_W     = 9;
  localparam int KIND_W     = 2;
  localparam int OUT_DATA_W = 40;

  localparam logic [WORD_W-1:0]  HDR_MASK      = 32'hffff_0000;
  localparam logic [WORD_W-1:0]  HDR_SYNC      = 32'h2301_0000;
  localparam logic [LIMIT_W-1:0] MAX_WORDS_RST = 20'd1000000;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_END_MARK = 2'd1,
    KIND_RESYNC   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] payload;
    logic [CH_W-1:0]   channel;
    logic              last;
    logic              spans_transfers;
    logic              overflow_drop;
  } result_t;

  // Result handed from the core to the output buffer.
  typedef struct packed {
    logic    valid;
    result_t res;
  } result_msg_t;

endpackage

`default_nettype wire

FILE: hdl/dfr_core.sv
// ----------------------------------------------------------------------------
// dfr_core
// Header/payload tracking, per-channel word counts and spanned flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_core
  import dfr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [LIMIT_W-1:0]  cfg_wdata,
  input  wire logic                step_en,
  input  wire logic [WORD_W-1:0]   in_word,
  input  wire logic                in_tstart,
  output result_msg_t              result
);

  logic [LIMIT_W-1:0] max_packet_words;
  logic               in_payload, in_payload_next;
  logic [LEFT_W-1:0]  words_left, words_left_next;
  logic [CH_W-1:0]    segment_channel, segment_channel_next;
  logic               segment_ends, segment_ends_next;
  logic [COUNT_W-1:0] word_count [CHANNELS];
  logic [COUNT_W-1:0] word_count_next [CHANNELS];
  logic [CHANNELS-1:0] spanned, spanned_next;

  logic [CHANNELS-1:0] nonzero;
  logic [CHANNELS-1:0] seg_onehot;
  logic [CHANNELS-1:0] span_t;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                final_word;
  logic [CH_W-1:0]     hdr_ch;
  logic                hdr_ok;
  logic                hdr_ends;
  logic [7:0]          hdr_pairs;
  logic                hdr_span;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      nonzero[c] = |word_count[c];
    end
  end

  assign seg_onehot = CHANNELS'(1) << segment_channel;
  assign span_t     = spanned | ({CHANNELS{in_tstart}} &
                      (nonzero | (in_payload ? seg_onehot : '0)));

  assign cnt_inc    = word_count[segment_channel] + COUNT_W'(1);
  assign final_word = (words_left <= LEFT_W'(1));

  assign hdr_ch     = in_word[11:8];
  assign hdr_ends   = in_word[12];
  assign hdr_pairs  = in_word[7:0];
  assign hdr_ok     = ((in_word & HDR_MASK) == HDR_SYNC) &&
                      ({1'b0, hdr_ch} < (CH_W+1)'(CHANNELS));
  // A packet that starts fresh forgets any earlier transfer boundary
  assign hdr_span   = nonzero[hdr_ch] ? span_t[hdr_ch] : 1'b0;

  always_comb begin
    in_payload_next      = in_payload;
    words_left_next      = words_left;
    segment_channel_next = segment_channel;
    segment_ends_next    = segment_ends;
    word_count_next      = word_count;
    spanned_next         = spanned;
    result               = '0;

    if (step_en) begin
      spanned_next = span_t;
      if (in_payload) begin
        result.valid       = 1'b1;
        result.res.kind    = KIND_PAYLOAD;
        result.res.payload = in_word;
        result.res.channel = segment_channel;
        word_count_next[segment_channel] = cnt_inc;
        if (final_word) begin
          words_left_next = '0;
          in_payload_next = 1'b0;
          if (segment_ends) begin
            result.res.last            = 1'b1;
            result.res.spans_transfers = span_t[segment_channel];
            word_count_next[segment_channel] = '0;
          end else if (cnt_inc > {1'b0, max_packet_words}) begin
            result.res.overflow_drop = 1'b1;
            word_count_next[segment_channel] = '0;
          end
        end else begin
          words_left_next = words_left - LEFT_W'(1);
        end
      end else if (!hdr_ok) begin
        result.valid       = 1'b1;
        result.res.kind    = KIND_RESYNC;
        result.res.payload = in_word;
      end else begin
        spanned_next[hdr_ch] = hdr_span;
        if (hdr_pairs == '0) begin
          if (hdr_ends) begin
            result.valid               = 1'b1;
            result.res.kind            = KIND_END_MARK;
            result.res.channel         = hdr_ch;
            result.res.last            = 1'b1;
            result.res.spans_transfers = hdr_span;
            word_count_next[hdr_ch]    = '0;
          end
        end else begin
          in_payload_next      = 1'b1;
          words_left_next      = {hdr_pairs, 1'b0};
          segment_channel_next = hdr_ch;
          segment_ends_next    = hdr_ends;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_words <= MAX_WORDS_RST;
      in_payload       <= 1'b0;
      words_left       <= '0;
      segment_channel  <= '0;
      segment_ends     <= 1'b0;
      spanned          <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        word_count[c] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        max_packet_words <= cfg_wdata;
      end
      in_payload      <= in_payload_next;
      words_left      <= words_left_next;
      segment_channel <= segment_channel_next;
      segment_ends    <= segment_ends_next;
      spanned         <= spanned_next;
      word_count      <= word_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dfr_skid.sv
// ----------------------------------------------------------------------------
// dfr_skid
// Output register with one skid entry, so results survive a receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_skid
  import dfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire result_msg_t  in_msg,
  output logic              full,
  output logic              out_valid,
  input  wire logic         out_ready,
  output result_t           out_res
);

  logic    skid_valid;
  result_t skid_res;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // Drain the skid entry first; no new result arrives while it is full
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_msg.valid;
      end
    end else if (in_msg.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : in_msg.res;
    end else if (in_msg.valid) begin
      skid_res <= in_msg.res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/multichannel_word_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// multichannel_word_stream_deframer_top
// Splits a 32-bit word stream into channel-tagged segments and packet ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one 32-bit word per item in s_tdata, with s_tuser high
//   on the first word of a host transfer. Output stream m_*: one result per
//   payload word, per bad header (resync) and per empty ending header.
//   Headers that open a segment produce no result.
//   The input register holds an accepted word for the state update, and its
//   result is registered in the output register before it shows on m_*.
//   Throughput: one word per cycle while the skid entry is empty; the input
//   register, state update and output register each take one item per clock.
//   A stalled receiver is absorbed by one skid entry behind the output
//   register; the input keeps taking words until that entry fills.
//   Reset: expects a header, clears all per-channel word counts and spanned
//   flags, and sets max_packet_words to 1000000. Write cfg_wdata with
//   cfg_wen only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_word_stream_deframer_top
  import dfr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [LIMIT_W-1:0]     cfg_wdata,   // max_packet_words
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [WORD_W-1:0]      s_tdata,     // [31:0] word
  input  wire logic                   s_tuser,     // [0] transfer_start
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,     // [31:0] payload, [35:32] channel,
                                                   // [36] spans_transfers,
                                                   // [37] overflow_drop, [39:38] zero
  output logic [KIND_W-1:0]           m_tuser,     // [1:0] kind
  output logic                        m_tlast      // last
);

  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_tstart;
  logic              skid_full;
  logic              step_en;
  result_msg_t       core_msg;
  result_t           out_res;

  assign step_en  = in_valid && !skid_full;
  assign s_tready = !in_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word   <= s_tdata;
      in_tstart <= s_tuser;
    end
  end

  dfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .in_word   (in_word),
    .in_tstart (in_tstart),
    .result    (core_msg)
  );

  dfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_msg    (core_msg),
    .full      (skid_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {2'b00, out_res.overflow_drop, out_res.spans_transfers,
                    out_res.channel, out_res.payload};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: hdl/dfr_checker.sv
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks on the deframer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dfr_checker
  import dfr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [KIND_W-1:0]     m_tuser,
  input wire logic                  m_tlast
);

  logic                         stalled;
  logic [OUT_DATA_W+KIND_W:0]   out_item;
  logic                         is_resync;
  logic                         is_marker;
  logic                         is_drop;

  assign stalled   = m_tvalid && !m_tready;
  assign out_item  = {m_tlast, m_tuser, m_tdata};
  assign is_resync = m_tvalid && (m_tuser == KIND_RESYNC);
  assign is_marker = m_tvalid && (m_tuser == KIND_END_MARK);
  assign is_drop   = m_tvalid && m_tdata[37];

  // Hold a stalled result
  `DFR_ASSERT(a_out_hold, clk, rst, stalled |=> m_tvalid && $stable(out_item))

  `DFR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // Resync carries no channel and never closes a packet
  `DFR_ASSERT(a_resync_shape, clk, rst, is_resync |-> !m_tlast && m_tdata[39:32] == 8'd0)

  `DFR_ASSERT(a_marker_shape, clk, rst, is_marker |-> m_tlast && m_tdata[31:0] == '0 && !m_tdata[37])

  // Drop only on a payload word of an open packet
  `DFR_ASSERT(a_drop_open, clk, rst, is_drop |-> !m_tlast && !m_tdata[36] && m_tuser == KIND_PAYLOAD)

endmodule

bind multichannel_word_stream_deframer_top dfr_checker u_dfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel word stream deframer. Words go in
// as headers, payload and noise with random transfer starts. The bench keeps
// its own copy of segment state, per-channel counts and spanned flags. Every
// result on m_* is compared with the oldest predicted result, while the word
// limit is swept across several settings.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 5;
  localparam int RANDOM_WORDS = 2000;
  localparam int SHOW_ERRORS  = 40;

  // Tracks deframer state per accepted word and holds the results it implies.
  class deframer_scoreboard;
    result_t            awaited_results[$];
    logic [LIMIT_W-1:0] word_limit;
    logic               in_payload;
    logic [LEFT_W-1:0]  words_left;
    logic [CH_W-1:0]    seg_channel;
    logic               seg_ends;
    logic [COUNT_W-1:0] channel_words[CHANNELS];
    logic               spanned[CHANNELS];
    int                 mismatches;
    int                 n_payload, n_markers, n_resyncs, n_ends, n_spans, n_drops;

    function new();
      word_limit = MAX_WORDS_RST;
      in_payload = 1'b0;
      words_left = '0;
      seg_channel = '0;
      seg_ends = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        channel_words[c] = '0;
        spanned[c] = 1'b0;
      end
      mismatches = 0;
      n_payload = 0; n_markers = 0; n_resyncs = 0;
      n_ends = 0; n_spans = 0; n_drops = 0;
    endfunction

    function void queue_result(result_t r);
      awaited_results = {awaited_results, r};
    endfunction

    function void note_word(logic [WORD_W-1:0] w, logic tstart);
      logic [CH_W-1:0]    ch;
      logic [7:0]         pairs;
      logic               ends;
      logic [COUNT_W-1:0] cnt;
      logic               last_word;
      result_t            r;
      r = '0;
      if (tstart) begin
        for (int c = 0; c < CHANNELS; c++)
          if (channel_words[c] != 0 || (in_payload && c == int'(seg_channel)))
            spanned[c] = 1'b1;
      end
      if (in_payload) begin
        ch = seg_channel;
        cnt = channel_words[ch] + 1'b1;
        last_word = (words_left <= 1);
        words_left = last_word ? '0 : words_left - 1'b1;
        channel_words[ch] = cnt;
        r.kind = KIND_PAYLOAD;
        r.payload = w;
        r.channel = ch;
        if (last_word) begin
          in_payload = 1'b0;
          if (seg_ends) begin
            r.last = 1'b1;
            r.spans_transfers = spanned[ch];
            channel_words[ch] = '0;
          end else if (cnt > {1'b0, word_limit}) begin
            r.overflow_drop = 1'b1;
            channel_words[ch] = '0;
          end
        end
        queue_result(r);
        return;
      end
      ch = w[11:8];
      pairs = w[7:0];
      ends = w[12];
      if ((w & HDR_MASK) != HDR_SYNC || int'(ch) >= CHANNELS) begin
        r.kind = KIND_RESYNC;
        r.payload = w;
        queue_result(r);
        return;
      end
      // a fresh packet forgets any earlier transfer boundary
      if (channel_words[ch] == 0)
        spanned[ch] = 1'b0;
      if (pairs == 0) begin
        if (ends) begin
          r.kind = KIND_END_MARK;
          r.channel = ch;
          r.last = 1'b1;
          r.spans_transfers = spanned[ch];
          channel_words[ch] = '0;
          queue_result(r);
        end
        return;
      end
      in_payload = 1'b1;
      words_left = {pairs, 1'b0};
      seg_channel = ch;
      seg_ends = ends;
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS)
          $display("%0t: unexpected result kind %0d data %h ch %0d last %b",
                   $time, got.kind, got.payload, got.channel, got.last);
        return;
      end
      exp_r = awaited_results[0];
      awaited_results.delete(0);
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS)
          $display("%0t: mismatch, expected kind %0d data %h ch %0d last %b span %b ovf %b,",
                   $time, exp_r.kind, exp_r.payload, exp_r.channel, exp_r.last,
                   exp_r.spans_transfers, exp_r.overflow_drop,
                   " got kind %0d data %h ch %0d last %b span %b ovf %b",
                   got.kind, got.payload, got.channel, got.last,
                   got.spans_transfers, got.overflow_drop);
      end
      case (exp_r.kind)
        KIND_PAYLOAD:  n_payload++;
        KIND_END_MARK: n_markers++;
        default:       n_resyncs++;
      endcase
      if (exp_r.last) n_ends++;
      if (exp_r.spans_transfers) n_spans++;
      if (exp_r.overflow_drop) n_drops++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [WORD_W-1:0]     s_tdata = '0;   // [31:0] word
  logic                  s_tuser = 1'b0; // [0] transfer_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] payload, [35:32] channel,
                                         // [36] spans_transfers, [37] overflow_drop
  logic [KIND_W-1:0]     m_tuser;        // [1:0] kind
  logic                  m_tlast;

  deframer_scoreboard sb = new();
  int cycles = 0;
  int words_sent = 0;
  int ready_left = 0;
  logic calm = 1'b0;

  multichannel_word_stream_deframer_top dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: bursts of ready and stall, none while calm.
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
      ready_left = 0;
    end else if (ready_left == 0) begin
      m_tready <= ($urandom_range(0, 99) < 65);
      ready_left = idle_len();
    end else begin
      ready_left--;
    end
  end

  // Watch both handshakes; a word passes the input and output registers first, so no result can meet its word.
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind = kind_t'(m_tuser);
        got.payload = m_tdata[31:0];
        got.channel = m_tdata[35:32];
        got.last = m_tlast;
        got.spans_transfers = m_tdata[36];
        got.overflow_drop = m_tdata[37];
        sb.check_result(got);
      end
      if (s_tvalid && s_tready)
        sb.note_word(s_tdata, s_tuser);
    end
  end

  task automatic send_word(logic [WORD_W-1:0] w, logic tstart);
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= tstart;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  function automatic logic coin_start();
    return ($urandom_range(0, 99) < 8);
  endfunction

  task automatic send_segment(logic [CH_W-1:0] ch, logic [7:0] pairs, logic ends);
    logic [WORD_W-1:0] w;
    send_word({HDR_SYNC[31:16], 3'($urandom), ends, ch, pairs}, coin_start());
    for (int i = 0; i < 2 * int'(pairs); i++) begin
      // payload that looks like a header must still pass through
      if ($urandom_range(0, 99) < 12)
        w = {HDR_SYNC[31:16], 16'($urandom)};
      else
        w = $urandom;
      send_word(w, coin_start());
    end
  endtask

  task automatic random_traffic(int n);
    int stop_at, r;
    logic [7:0] pairs;
    logic [CH_W-1:0] ch;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_word($urandom, coin_start());
      end else if (r < 9) begin
        // sync word with one bit off
        send_word((HDR_SYNC ^ (32'h1 << $urandom_range(16, 31))) | 16'($urandom),
                  coin_start());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) pairs = 8'd0;
        else if (r < 77) pairs = 8'($urandom_range(1, 4));
        else if (r < 99) pairs = 8'($urandom_range(5, 20));
        else pairs = 8'($urandom_range(21, 255));
        ch = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        send_segment(ch, pairs, $urandom_range(0, 99) < 40);
      end
    end
  endtask

  // Hold input until every predicted result is out and the pipeline is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_word_limit(logic [LIMIT_W-1:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.word_limit = v;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_word_limit(20'hfffff);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h2300_1fff, 1'b0);
    send_word(32'h2301_1f00, 1'b0);   // empty ending segment on channel 15
    send_word(32'h2301_0300, 1'b0);   // empty open segment: no result
    send_word(32'h2301_0001, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h2301_1000, 1'b1);   // transfer boundary inside payload
    send_word(32'h2301_1001, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'ha5a5_5a5a, 1'b0);
    send_word(32'h2301_0502, 1'b0);
    for (int i = 0; i < 4; i++) send_word($urandom, 1'b0);
    send_word(32'h2301_1500, 1'b1);   // end marker for a packet across transfers
    send_word(32'h2303_e2ff, 1'b1);   // bad sync, low half looks like a header

    drain();
    set_word_limit(20'd4);
    calm = 1'b1;
    send_segment(4'd7, 8'd2, 1'b0);   // exactly at the limit
    send_segment(4'd7, 8'd1, 1'b0);   // two words past the limit: drop
    send_segment(4'd7, 8'd0, 1'b1);
    calm = 1'b0;
    random_traffic(400);

    drain();
    set_word_limit(20'd1);
    random_traffic(300);

    drain();
    set_word_limit(MAX_WORDS_RST);
    calm = 1'b1;
    random_traffic(200);
    calm = 1'b0;
    send_segment(4'd15, 8'd255, 1'b1);
    random_traffic(400);

    drain();
    set_word_limit(20'($urandom_range(8, 200)));
    random_traffic(RANDOM_WORDS - 1840);

    drain();
    $display("%0d words in; %0d payload, %0d end markers, %0d resyncs out",
             words_sent, sb.n_payload, sb.n_markers, sb.n_resyncs);
    $display("%0d packet ends (%0d across transfers), %0d overflow drops, 5 limit settings",
             sb.n_ends, sb.n_spans, sb.n_drops);
    if (sb.mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
